/* design/vtdh_pkg.sv */
// vtdh_pkg: shared types and constants of the vertex triple dedup hash block
// item structs, controller/datapath command and status structs, hash multipliers
// no dependencies
package vtdh_pkg;

  localparam logic [31:0] HashP = 32'd73856093;
  localparam logic [31:0] HashT = 32'd19349663;
  localparam logic [31:0] HashN = 32'd83492791;

  localparam logic [12:0] BucketCountRst = 13'd4096;
  localparam logic        OpLookup       = 1'b0;
  localparam logic        OpClear        = 1'b1;
  localparam int          MulSteps       = 3;
  localparam int          DivSteps       = 32;

  typedef struct packed {
    logic               op;
    logic signed [31:0] pos_index;
    logic signed [31:0] tex_index;
    logic signed [31:0] norm_index;
  } in_item_t;

  typedef struct packed {
    logic [11:0]        vertex_index;
    logic               is_new;
    logic               table_full;
    logic signed [31:0] echo_pos;
    logic signed [31:0] echo_tex;
    logic signed [31:0] echo_norm;
  } out_item_t;

  typedef struct packed {
    logic       load;
    logic       clear;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       div_en;
    logic       head_take;
    logic       ent_take;
    logic       hit;
    logic       insert;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic walk;
  } sts_t;

endpackage

/* design/vertex_triple_dedup_hash_top.sv */
// vertex_triple_dedup_hash_top: chained hash deduplication of vertex index triples
// depends on vtdh_pkg, vtdh_ctrl, vtdh_datapath, vtdh_ram
//
// channel   direction  handshake              payload
// item in   input      start & !busy          in_item_i  (vtdh_pkg::in_item_t)
// result    output     res_valid_o, 1 cycle   res_item_o (vtdh_pkg::out_item_t)
// config    input      cfg_valid_i & ready    cfg_data_i (bucket count, 13 bit)
//
// a lookup strobes its result after hashing on the shared multiplier, the bit-serial
// remainder unit, the head read, one entry memory read per chain step and, on a miss,
// an insert step; busy falls in the result cycle
// a clear item resets the entry count and gives no result
// asynchronous active-low reset, no clearing pass: emptiness follows from the entry count
// results are strobed once; the receiver cannot stall
module vertex_triple_dedup_hash_top #(
  parameter int ENTRIES = 4096,
  parameter int BUCKETS = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  vtdh_pkg::in_item_t  in_item_i,
  output logic                res_valid_o,
  output vtdh_pkg::out_item_t res_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [12:0]         cfg_data_i
);

  vtdh_pkg::cmd_t cmd;
  vtdh_pkg::sts_t sts;
  logic [12:0]    bucket_count_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_count_q <= vtdh_pkg::BucketCountRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      bucket_count_q <= cfg_data_i;
    end
  end

  vtdh_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start && !busy),
    .op_i    (in_item_i.op),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  vtdh_datapath #(
    .ENTRIES (ENTRIES),
    .BUCKETS (BUCKETS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .in_item_i      (in_item_i),
    .bucket_count_i (bucket_count_q),
    .sts_o          (sts),
    .res_valid_o    (res_valid_o),
    .res_item_o     (res_item_o)
  );

endmodule

/* design/vtdh_ram.sv */
// vtdh_ram: generic simple dual port ram, one write and one registered read port
// contents start at zero so an unwritten location reads a defined value
// no dependencies
module vtdh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      mem_q[i] = '0;
    end
  end

  always @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* design/vtdh_ctrl.sv */
// vtdh_ctrl: sequencer for hash, modulo, chain walk and insert
// depends on vtdh_pkg
module vtdh_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          op_i,
  input  vtdh_pkg::sts_t sts_i,
  output vtdh_pkg::cmd_t cmd_o,
  output logic          busy_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_DIV, S_HEAD, S_HEADD, S_ENT, S_INS
  } state_e;

  state_e     state_q;
  logic [4:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (start_i && op_i == vtdh_pkg::OpLookup) begin
            state_q <= S_MUL;
            cnt_q   <= '0;
          end
        end
        S_MUL: begin
          if (cnt_q == 5'(vtdh_pkg::MulSteps - 1)) begin
            state_q <= S_DIV;
            cnt_q   <= '0;
          end else begin
            cnt_q <= cnt_q + 5'd1;
          end
        end
        S_DIV: begin
          if (cnt_q == 5'(vtdh_pkg::DivSteps - 1)) begin
            state_q <= S_HEAD;
          end
          cnt_q <= cnt_q + 5'd1;
        end
        S_HEAD:  state_q <= S_HEADD;
        S_HEADD: state_q <= S_ENT;
        S_ENT: begin
          priority if (sts_i.hit) begin
            state_q <= S_IDLE;
          end else if (sts_i.walk) begin
            state_q <= S_ENT;
          end else begin
            state_q <= S_INS;
          end
        end
        S_INS:   state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.load      = (state_q == S_IDLE) && start_i;
    cmd_o.clear     = (state_q == S_IDLE) && start_i && op_i == vtdh_pkg::OpClear;
    cmd_o.mul_en    = (state_q == S_MUL);
    cmd_o.mul_sel   = cnt_q[1:0];
    cmd_o.div_en    = (state_q == S_DIV);
    cmd_o.head_take = (state_q == S_HEADD);
    cmd_o.ent_take  = (state_q == S_ENT);
    cmd_o.hit       = (state_q == S_ENT) && sts_i.hit;
    cmd_o.insert    = (state_q == S_INS);
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

/* design/vtdh_datapath.sv */
// vtdh_datapath: hash, remainder unit, head and entry memories, result register
// depends on vtdh_pkg and vtdh_ram
module vtdh_datapath #(
  parameter int ENTRIES = 4096,
  parameter int BUCKETS = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  vtdh_pkg::cmd_t      cmd_i,
  input  vtdh_pkg::in_item_t  in_item_i,
  input  logic [12:0]         bucket_count_i,
  output vtdh_pkg::sts_t      sts_o,
  output logic                res_valid_o,
  output vtdh_pkg::out_item_t res_item_o
);

  localparam int IW = $clog2(ENTRIES);
  localparam int BW = $clog2(BUCKETS);
  localparam int DW = $clog2(BUCKETS + 1);

  typedef struct packed {
    logic [BW-1:0] bucket;
    logic          lv;
    logic [IW-1:0] link;
    logic [31:0]   p;
    logic [31:0]   t;
    logic [31:0]   n;
  } ent_t;

  vtdh_pkg::in_item_t key_q;
  logic [31:0]        hash_q;
  logic [DW-1:0]      div_q;
  logic [DW-1:0]      rem_q;
  logic [IW:0]        cnt_q;
  logic [IW-1:0]      cur_q;
  logic [IW-1:0]      head_q;
  logic               cur_valid_q;
  logic               first_q;
  logic               head_valid_q;

  logic [31:0]   eff;
  logic [31:0]   mul_a;
  logic [31:0]   mul_k;
  logic [31:0]   prod;
  logic [DW:0]   trial;
  logic [BW-1:0] bucket;
  logic [IW-1:0] head_rdata;
  ent_t          ent_rdata;
  ent_t          ent_wdata;
  logic [IW-1:0] ent_raddr;
  logic          full;
  logic          v;
  logic          match;

  always_comb begin
    eff = 32'(bucket_count_i);
    if (eff == 32'd0) begin
      eff = 32'd1;
    end else if (eff > 32'(BUCKETS)) begin
      eff = 32'(BUCKETS);
    end
  end

  always_comb begin
    unique case (cmd_i.mul_sel)
      2'd0: begin
        mul_a = key_q.pos_index;
        mul_k = vtdh_pkg::HashP;
      end
      2'd1: begin
        mul_a = key_q.tex_index;
        mul_k = vtdh_pkg::HashT;
      end
      default: begin
        mul_a = key_q.norm_index;
        mul_k = vtdh_pkg::HashN;
      end
    endcase
    prod = mul_a * mul_k;
  end

  assign trial  = {rem_q, hash_q[31]};
  assign bucket = rem_q[BW-1:0];
  assign full   = (cnt_q == (IW+1)'(ENTRIES));

  always_comb begin
    if (cur_valid_q && (!first_q || ent_rdata.bucket == bucket)) begin
      v = 1'b1;
    end else begin
      v = 1'b0;
    end
    if (ent_rdata.p == key_q.pos_index && ent_rdata.t == key_q.tex_index
        && ent_rdata.n == key_q.norm_index) begin
      match = 1'b1;
    end else begin
      match = 1'b0;
    end
    sts_o.hit  = v && match;
    if (v && !match && ent_rdata.lv) begin
      sts_o.walk = 1'b1;
    end else begin
      sts_o.walk = 1'b0;
    end
  end

  assign ent_raddr = cmd_i.head_take ? head_rdata : ent_rdata.link;

  always_comb begin
    ent_wdata.bucket = bucket;
    ent_wdata.lv     = head_valid_q;
    ent_wdata.link   = head_q;
    ent_wdata.p      = key_q.pos_index;
    ent_wdata.t      = key_q.tex_index;
    ent_wdata.n      = key_q.norm_index;
  end

  vtdh_ram #(.WIDTH(IW), .DEPTH(BUCKETS)) u_head_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.insert && !full),
    .waddr_i (bucket),
    .wdata_i (cnt_q[IW-1:0]),
    .raddr_i (bucket),
    .rdata_o (head_rdata)
  );

  vtdh_ram #(.WIDTH($bits(ent_t)), .DEPTH(ENTRIES)) u_ent_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.insert && !full),
    .waddr_i (cnt_q[IW-1:0]),
    .wdata_i (ent_wdata),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q  <= in_item_i;
      hash_q <= '0;
      div_q  <= DW'(eff);
      rem_q  <= '0;
    end
    if (cmd_i.mul_en) begin
      hash_q <= hash_q ^ prod;
    end
    if (cmd_i.div_en) begin
      hash_q <= {hash_q[30:0], 1'b0};
      if (trial >= {1'b0, div_q}) begin
        rem_q <= DW'(trial - {1'b0, div_q});
      end else begin
        rem_q <= trial[DW-1:0];
      end
    end
    if (cmd_i.head_take) begin
      head_q  <= head_rdata;
      cur_q   <= head_rdata;
      first_q <= 1'b1;
      if ((IW+1)'(head_rdata) < cnt_q) begin
        cur_valid_q <= 1'b1;
      end else begin
        cur_valid_q <= 1'b0;
      end
    end
    if (cmd_i.ent_take) begin
      cur_q   <= ent_rdata.link;
      first_q <= 1'b0;
      if (first_q) begin
        head_valid_q <= v;
      end
      if (sts_o.walk) begin
        cur_valid_q <= 1'b1;
      end else begin
        cur_valid_q <= 1'b0;
      end
    end
    if (cmd_i.hit) begin
      res_item_o.vertex_index <= 12'(cur_q);
      res_item_o.is_new       <= 1'b0;
      res_item_o.table_full   <= 1'b0;
    end
    if (cmd_i.insert) begin
      res_item_o.vertex_index <= full ? 12'd0 : 12'(cnt_q);
      res_item_o.is_new       <= !full;
      res_item_o.table_full   <= full;
    end
    if (cmd_i.hit || cmd_i.insert) begin
      res_item_o.echo_pos  <= key_q.pos_index;
      res_item_o.echo_tex  <= key_q.tex_index;
      res_item_o.echo_norm <= key_q.norm_index;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      res_valid_o <= 1'b0;
    end else begin
      res_valid_o <= cmd_i.hit || cmd_i.insert;
      if (cmd_i.clear) begin
        cnt_q <= '0;
      end else if (cmd_i.insert && !full) begin
        cnt_q <= cnt_q + (IW+1)'(1);
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (IW+1)'(ENTRIES))
    else $error("entry count beyond store depth");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.insert && !full |=> cnt_q == $past(cnt_q) + (IW+1)'(1))
    else $error("insert did not advance entry count");

  a_res_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(cmd_i.hit || cmd_i.insert))
    else $error("result strobe without hit or insert");

  a_full_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_item_o.table_full |-> !res_item_o.is_new)
    else $error("full item flagged as new");

endmodule
